// File: rtl/core/bctd_pkg.sv
// Shared types, constants and divide helpers for the texture block decoder.
package bctd_pkg;

  localparam int unsigned AddrW = 3;

  typedef enum logic [1:0] {
    FMT_COLOR    = 2'd0,
    FMT_EXPLICIT = 2'd1,
    FMT_INTERP   = 2'd2
  } fmt_e;

  typedef enum logic [0:0] {
    REG_FORMAT = 1'b0
  } reg_idx_e;

  // Stage 1 output: widened endpoints and raw interpolation sums.
  typedef struct packed {
    logic [2:0][7:0]  c0;
    logic [2:0][7:0]  c1;
    logic [2:0][9:0]  sum2;
    logic [2:0][9:0]  sum3;
    logic [2:0][7:0]  avg;
    logic             four;
    logic [5:0][10:0] asum;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             agt;
    logic [31:0]      idx;
    logic [63:0]      abits;
    logic [1:0]       fmt;
  } s1_t;

  // Stage 2 output: full palette and alpha levels.
  typedef struct packed {
    logic [3:0][7:0] blu;
    logic [3:0][7:0] grn;
    logic [3:0][7:0] red;
    logic            four;
    logic [7:0][7:0] lev;
    logic [31:0]     idx;
    logic [63:0]     abits;
    logic [1:0]      fmt;
  } blk_t;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = x * 11'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = x * 11'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = x * 12'd2341;
    return p[21:14];
  endfunction

endpackage

// File: rtl/core/bc_texture_block_decoder.sv
// Top level of the BC1/BC2/BC3 texture block decoder with APB format register.
//
// Input channel: one compressed 4x4 block per beat (in_valid_i / in_ready_o),
// with endpoints, color indices, alpha bits and alpha levels as separate ports.
// Output channel: one decoded pixel per beat (out_valid_o / out_ready_i), the
// sixteen pixels of a block in raster order, last_pixel_o on pixel 15.
// Pipeline: stage 1 widens endpoints and forms sums, stage 2 performs the
// divisions by 3, 5 and 7, stage 3 walks the pixels into the output register.
// A block is registered in stage 1, stage 2 and the stage 3 block register
// before its pixels pass the output register, sixteen beats on the single
// pixel port; up to two further blocks are taken and held in stages 1 and 2.
// Configuration: block_format at byte address 0 (0 color, 1 explicit alpha,
// 2 interpolated alpha, 3 treated as color); the format is captured with each
// block on entry. Write only while idle.
// Reset: all stages empty, block_format cleared to color only.
// Stall: when out_ready_i is low the output holds and the pipeline backs up;
// no pixel is lost or repeated.
module bc_texture_block_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bctd_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [15:0]                color_endpoint0_i,
  input  logic [15:0]                color_endpoint1_i,
  input  logic [31:0]                color_indices_i,
  input  logic [63:0]                alpha_bits_i,
  input  logic [7:0]                 alpha_level0_i,
  input  logic [7:0]                 alpha_level1_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 blue_o,
  output logic [7:0]                 green_o,
  output logic [7:0]                 red_o,
  output logic [7:0]                 opacity_o,
  output logic [3:0]                 pixel_number_o,
  output logic                       last_pixel_o
);
  import bctd_pkg::*;

  logic [1:0] fmt_q;
  logic       sel_fmt;

  logic s1_valid, s1_ready, s2_valid, s2_ready;
  s1_t  s1;
  blk_t blk;

  assign pready  = 1'b1;
  assign sel_fmt = paddr[AddrW-1] == REG_FORMAT;
  assign prdata  = sel_fmt ? {30'd0, fmt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_COLOR;
    end else if (psel && penable && pwrite && pready && sel_fmt) begin
      fmt_q <= pwdata[1:0];
    end
  end

  bctd_palette u_palette (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (in_valid_i),
    .ready_o           (in_ready_o),
    .color_endpoint0_i (color_endpoint0_i),
    .color_endpoint1_i (color_endpoint1_i),
    .color_indices_i   (color_indices_i),
    .alpha_bits_i      (alpha_bits_i),
    .alpha_level0_i    (alpha_level0_i),
    .alpha_level1_i    (alpha_level1_i),
    .fmt_i             (fmt_q),
    .valid_o           (s1_valid),
    .ready_i           (s1_ready),
    .s1_o              (s1)
  );

  bctd_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .blk_o   (blk)
  );

  bctd_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blk_valid_i    (s2_valid),
    .blk_ready_o    (s2_ready),
    .blk_i          (blk),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blue_o         (blue_o),
    .green_o        (green_o),
    .red_o          (red_o),
    .opacity_o      (opacity_o),
    .pixel_number_o (pixel_number_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// File: rtl/core/bctd_palette.sv
// Stage 1: endpoint widening, palette and alpha level sums.
module bctd_palette (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [15:0]    color_endpoint0_i,
  input  logic [15:0]    color_endpoint1_i,
  input  logic [31:0]    color_indices_i,
  input  logic [63:0]    alpha_bits_i,
  input  logic [7:0]     alpha_level0_i,
  input  logic [7:0]     alpha_level1_i,
  input  logic [1:0]     fmt_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bctd_pkg::s1_t  s1_o
);
  import bctd_pkg::*;

  logic vld_q;
  s1_t  s1_d, s1_q;

  always_comb begin
    s1_d.c0[0] = {color_endpoint0_i[4:0], color_endpoint0_i[4:2]};
    s1_d.c0[1] = {color_endpoint0_i[10:5], color_endpoint0_i[10:9]};
    s1_d.c0[2] = {color_endpoint0_i[15:11], color_endpoint0_i[15:13]};
    s1_d.c1[0] = {color_endpoint1_i[4:0], color_endpoint1_i[4:2]};
    s1_d.c1[1] = {color_endpoint1_i[10:5], color_endpoint1_i[10:9]};
    s1_d.c1[2] = {color_endpoint1_i[15:11], color_endpoint1_i[15:13]};
    for (int ch = 0; ch < 3; ch++) begin
      s1_d.sum2[ch] = {1'b0, s1_d.c0[ch], 1'b0} + {2'b0, s1_d.c1[ch]} + 10'd1;
      s1_d.sum3[ch] = {1'b0, s1_d.c1[ch], 1'b0} + {2'b0, s1_d.c0[ch]} + 10'd1;
      s1_d.avg[ch]  = 8'(({1'b0, s1_d.c0[ch]} + {1'b0, s1_d.c1[ch]}) >> 1);
    end
    s1_d.four = color_endpoint0_i > color_endpoint1_i;
    s1_d.agt  = alpha_level0_i > alpha_level1_i;
    for (int k = 1; k <= 6; k++) begin
      if (s1_d.agt) begin
        s1_d.asum[k-1] = 11'(7 - k) * {3'b0, alpha_level0_i} + 11'(k) * {3'b0, alpha_level1_i};
      end else if (k <= 4) begin
        s1_d.asum[k-1] = 11'(5 - k) * {3'b0, alpha_level0_i} + 11'(k) * {3'b0, alpha_level1_i};
      end else begin
        s1_d.asum[k-1] = 11'd0;
      end
    end
    s1_d.a0    = alpha_level0_i;
    s1_d.a1    = alpha_level1_i;
    s1_d.idx   = color_indices_i;
    s1_d.abits = alpha_bits_i;
    s1_d.fmt   = fmt_i;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign s1_o    = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      s1_q <= s1_d;
    end
  end

endmodule

// File: rtl/core/bctd_interp.sv
// Stage 2: constant divisions giving the color palette and alpha levels.
module bctd_interp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bctd_pkg::s1_t  s1_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bctd_pkg::blk_t blk_o
);
  import bctd_pkg::*;

  logic vld_q;
  blk_t blk_d, blk_q;
  logic [2:0][7:0] e0, e1, e2, e3;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      e0[ch] = s1_i.c0[ch];
      e1[ch] = s1_i.c1[ch];
      e2[ch] = s1_i.four ? div3(s1_i.sum2[ch]) : s1_i.avg[ch];
      e3[ch] = s1_i.four ? div3(s1_i.sum3[ch]) : 8'd0;
    end
    blk_d.blu = {e3[0], e2[0], e1[0], e0[0]};
    blk_d.grn = {e3[1], e2[1], e1[1], e0[1]};
    blk_d.red = {e3[2], e2[2], e1[2], e0[2]};
    blk_d.four = s1_i.four;
    blk_d.lev[0] = s1_i.a0;
    blk_d.lev[1] = s1_i.a1;
    for (int k = 1; k <= 6; k++) begin
      if (s1_i.agt) begin
        blk_d.lev[k+1] = div7(s1_i.asum[k-1]);
      end else if (k <= 4) begin
        blk_d.lev[k+1] = div5(s1_i.asum[k-1]);
      end else if (k == 5) begin
        blk_d.lev[k+1] = 8'd0;
      end else begin
        blk_d.lev[k+1] = 8'hFF;
      end
    end
    blk_d.idx   = s1_i.idx;
    blk_d.abits = s1_i.abits;
    blk_d.fmt   = s1_i.fmt;
  end

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign blk_o   = blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      blk_q <= blk_d;
    end
  end

endmodule

// File: rtl/core/bctd_serializer.sv
// Stage 3: per-pixel palette lookup and output register, one pixel a beat.
module bctd_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           blk_valid_i,
  output logic           blk_ready_o,
  input  bctd_pkg::blk_t blk_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     blue_o,
  output logic [7:0]     green_o,
  output logic [7:0]     red_o,
  output logic [7:0]     opacity_o,
  output logic [3:0]     pixel_number_o,
  output logic           last_pixel_o
);
  import bctd_pkg::*;

  logic        busy_q, out_valid_q;
  logic [3:0]  cnt_q;
  blk_t        blk_q;
  logic [31:0] idx_q;
  logic [63:0] abits_q;
  logic [7:0]  blue_q, green_q, red_q, opacity_q;
  logic [3:0]  pix_q;
  logic        last_q;

  logic        load, take, at_last;
  logic [1:0]  ci;
  logic [7:0]  alpha;

  assign load        = busy_q && (!out_valid_q || out_ready_i);
  assign at_last     = cnt_q == 4'hF;
  assign blk_ready_o = !busy_q || (load && at_last);
  assign take        = blk_valid_i && blk_ready_o;
  assign ci          = idx_q[1:0];

  always_comb begin
    if (blk_q.fmt == FMT_EXPLICIT) begin
      alpha = {abits_q[3:0], abits_q[3:0]};
    end else if (blk_q.fmt == FMT_INTERP) begin
      alpha = blk_q.lev[abits_q[2:0]];
    end else begin
      alpha = (!blk_q.four && ci == 2'd3) ? 8'd0 : 8'hFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (load) begin
        cnt_q <= cnt_q + 4'd1;
        if (at_last) begin
          busy_q <= 1'b0;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blue_q    <= blk_q.blu[ci];
      green_q   <= blk_q.grn[ci];
      red_q     <= blk_q.red[ci];
      opacity_q <= alpha;
      pix_q     <= cnt_q;
      last_q    <= at_last;
    end
    if (take) begin
      blk_q   <= blk_i;
      idx_q   <= blk_i.idx;
      abits_q <= blk_i.abits;
    end else if (load) begin
      idx_q   <= idx_q >> 2;
      abits_q <= (blk_q.fmt == FMT_INTERP) ? abits_q >> 3 : abits_q >> 4;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign blue_o         = blue_q;
  assign green_o        = green_q;
  assign red_o          = red_q;
  assign opacity_o      = opacity_q;
  assign pixel_number_o = pix_q;
  assign last_pixel_o   = last_q;

  a_no_take_mid_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !at_last) |-> !blk_ready_o)
    else $error("block taken before sixteenth pixel");

  a_last_is_fifteen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (pix_q == 4'hF))
    else $error("last pixel flag on wrong pixel");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !take) |=> (cnt_q == $past(cnt_q) + 4'd1))
    else $error("pixel counter did not advance");

  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && pix_q == $past(cnt_q)))
    else $error("loaded pixel not presented");

endmodule

// File: tb/tb_bc_texture_block_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for bc_texture_block_decoder: predicts every pixel of each block beat.
module tb_bc_texture_block_decoder;
  import bctd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 12;
  localparam int MaxPrinted = 40;
  localparam logic [1:0] FmtUnused = 2'd3;
  localparam logic [AddrW-1:0] FormatAddr = AddrW'(4 * REG_FORMAT);

  typedef struct packed {
    logic [15:0] ep0;
    logic [15:0] ep1;
    logic [31:0] idx;
    logic [63:0] abits;
    logic [7:0]  lvl0;
    logic [7:0]  lvl1;
  } tex_block_t;

  typedef struct packed {
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [3:0] num;
    logic       last;
  } pixel_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [15:0]       color_endpoint0_i = '0;
  logic [15:0]       color_endpoint1_i = '0;
  logic [31:0]       color_indices_i = '0;
  logic [63:0]       alpha_bits_i = '0;
  logic [7:0]        alpha_level0_i = '0;
  logic [7:0]        alpha_level1_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        blue_o;
  logic [7:0]        green_o;
  logic [7:0]        red_o;
  logic [7:0]        opacity_o;
  logic [3:0]        pixel_number_o;
  logic              last_pixel_o;

  tex_block_t block_q[$];
  pixel_t     pixel_q[$];
  logic [1:0] fmt_shadow = FMT_COLOR;
  logic       in_fire = 1'b0;
  logic       rx_hold_on = 1'b0;
  bit         stall_armed = 1'b0;
  int         stall_at = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         blocks_in = 0;
  int         pixels_out = 0;
  int         err_cnt = 0;
  int         cycle_cnt = 0;

  bc_texture_block_decoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .color_endpoint0_i(color_endpoint0_i),
    .color_endpoint1_i(color_endpoint1_i),
    .color_indices_i  (color_indices_i),
    .alpha_bits_i     (alpha_bits_i),
    .alpha_level0_i   (alpha_level0_i),
    .alpha_level1_i   (alpha_level1_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .blue_o           (blue_o),
    .green_o          (green_o),
    .red_o            (red_o),
    .opacity_o        (opacity_o),
    .pixel_number_o   (pixel_number_o),
    .last_pixel_o     (last_pixel_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    err_cnt++;
    if (err_cnt <= MaxPrinted) begin
      $display("ERROR @%0t: %s", $realtime, what);
    end
  endtask

  // {red, green, blue}, each widened to 8 bits by bit replication
  function automatic logic [23:0] widen_rgb(input logic [15:0] v);
    return {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
  endfunction

  function automatic void decode_block(input tex_block_t blk, input logic [1:0] fmt);
    logic [23:0] rgb0;
    logic [23:0] rgb1;
    int          c0;
    int          c1;
    int          pal[4][4];
    int          lvl[8];
    bit          four;
    int          ci;
    pixel_t      px;
    rgb0 = widen_rgb(blk.ep0);
    rgb1 = widen_rgb(blk.ep1);
    four = blk.ep0 > blk.ep1;
    for (int ch = 0; ch < 3; ch++) begin
      c0 = rgb0[8*ch +: 8];
      c1 = rgb1[8*ch +: 8];
      pal[0][ch] = c0;
      pal[1][ch] = c1;
      pal[2][ch] = four ? (2 * c0 + c1 + 1) / 3 : (c0 + c1) / 2;
      pal[3][ch] = four ? (2 * c1 + c0 + 1) / 3 : 0;
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    pal[3][3] = four ? 255 : 0;
    lvl[0] = blk.lvl0;
    lvl[1] = blk.lvl1;
    if (blk.lvl0 > blk.lvl1) begin
      for (int k = 1; k <= 6; k++) lvl[k+1] = ((7 - k) * lvl[0] + k * lvl[1]) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) lvl[k+1] = ((5 - k) * lvl[0] + k * lvl[1]) / 5;
      lvl[6] = 0;
      lvl[7] = 255;
    end
    for (int p = 0; p < 16; p++) begin
      ci = blk.idx[2*p +: 2];
      px.blu = 8'(pal[ci][0]);
      px.grn = 8'(pal[ci][1]);
      px.red = 8'(pal[ci][2]);
      px.alpha = 8'(pal[ci][3]);
      if (fmt == FMT_EXPLICIT) begin
        px.alpha = {blk.abits[4*p +: 4], blk.abits[4*p +: 4]};
      end else if (fmt == FMT_INTERP) begin
        px.alpha = 8'(lvl[blk.abits[3*p +: 3]]);
      end
      px.num = 4'(p);
      px.last = (p == 15);
      pixel_q.push_back(px);
    end
  endfunction

  function automatic tex_block_t rand_block();
    tex_block_t b;
    b.ep0 = 16'($urandom);
    case ($urandom_range(0, 5))
      0: b.ep1 = b.ep0;
      1: b.ep1 = '0;
      2: b.ep1 = '1;
      default: b.ep1 = 16'($urandom);
    endcase
    b.idx = $urandom;
    b.abits = {$urandom, $urandom};
    b.lvl0 = 8'($urandom);
    case ($urandom_range(0, 5))
      0: b.lvl1 = b.lvl0;
      1: b.lvl1 = '0;
      2: b.lvl1 = '1;
      default: b.lvl1 = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic queue_block(input logic [15:0] e0, input logic [15:0] e1,
                             input logic [31:0] ix, input logic [63:0] ab,
                             input logic [7:0] l0, input logic [7:0] l1);
    block_q.push_back({e0, e1, ix, ab, l0, l1});
  endtask

  task automatic queue_random(input int n);
    repeat (n) block_q.push_back(rand_block());
  endtask

  task automatic drain();
    while (block_q.size() != 0 || in_valid_i || pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write the format register, then read it back
  task automatic set_format(input logic [1:0] f);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= FormatAddr;
    pwdata <= {30'b0, f};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== {30'b0, f}) begin
      report($sformatf("format readback: expected %0d, got 0x%08h", f, rd));
    end
  endtask

  // block driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (block_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        tex_block_t b;
        b = block_q.pop_front();
        in_valid_i <= 1'b1;
        color_endpoint0_i <= b.ep0;
        color_endpoint1_i <= b.ep1;
        color_indices_i <= b.idx;
        alpha_bits_i <= b.abits;
        alpha_level0_i <= b.lvl0;
        alpha_level1_i <= b.lvl1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // pixel receiver
  always @(negedge clk_i) begin
    out_ready_i <= !rx_hold_on && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // long output stall so the pipeline fills and in_ready_o drops
  initial begin : rx_hold
    wait (stall_armed);
    @(negedge clk_i);
    while (blocks_in < stall_at) @(negedge clk_i);
    rx_hold_on <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    rx_hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : mon
    pixel_t got;
    pixel_t want;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == FormatAddr) begin
        fmt_shadow <= pwdata[1:0];
      end
      if (out_valid_o && out_ready_i) begin
        got = {blue_o, green_o, red_o, opacity_o, pixel_number_o, last_pixel_o};
        pixels_out++;
        if (pixel_q.size() == 0) begin
          report($sformatf("pixel beat %0d with no block pending", pixel_number_o));
        end else begin
          want = pixel_q.pop_front();
          if (got.blu !== want.blu)
            report($sformatf("px %0d blue: exp %0d got %0d", want.num, want.blu, got.blu));
          if (got.grn !== want.grn)
            report($sformatf("px %0d green: exp %0d got %0d", want.num, want.grn, got.grn));
          if (got.red !== want.red)
            report($sformatf("px %0d red: exp %0d got %0d", want.num, want.red, got.red));
          if (got.alpha !== want.alpha)
            report($sformatf("px %0d opacity: exp %0d got %0d", want.num, want.alpha,
                             got.alpha));
          if (got.num !== want.num)
            report($sformatf("pixel_number: exp %0d got %0d", want.num, got.num));
          if (got.last !== want.last)
            report($sformatf("px %0d last_pixel: exp %0b got %0b", want.num, want.last,
                             got.last));
        end
      end
      if (in_valid_i && in_ready_o) begin
        decode_block({color_endpoint0_i, color_endpoint1_i, color_indices_i, alpha_bits_i,
                      alpha_level0_i, alpha_level1_i}, fmt_shadow);
        blocks_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt, pixel_q.size());
      $display("tb_bc_texture_block_decoder: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 67;
    set_format(FMT_COLOR);
    queue_block(16'h0000, 16'h0000, 32'h0000_0000, 64'h0, 8'h00, 8'h00);
    queue_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, 8'hFF, 8'hFF);
    queue_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 64'h0, 8'h00, 8'h00);
    queue_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 64'h0, 8'h00, 8'h00);
    queue_block(16'h7BEF, 16'h7BEF, 32'hE4E4_E4E4, 64'h0, 8'h00, 8'h00);
    queue_block(16'hF81F, 16'h07E0, 32'h1B1B_1B1B, 64'h0, 8'h00, 8'h00);
    queue_random(50);
    drain();

    set_format(FMT_EXPLICIT);
    queue_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 64'hFEDC_BA98_7654_3210, 8'h00, 8'h00);
    queue_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 64'h0123_4567_89AB_CDEF, 8'h00, 8'h00);
    queue_block(16'h1234, 16'h1234, 32'h4E4E_4E4E, 64'h0, 8'h00, 8'h00);
    queue_block(16'h0841, 16'hF7BE, 32'hFFFF_FFFF, '1, 8'h00, 8'h00);
    queue_random(50);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 25;
    set_format(FMT_INTERP);
    queue_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 64'h0000_FAC6_88FA_C688, 8'hFF, 8'h00);
    queue_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 64'h0000_FAC6_88FA_C688, 8'h00, 8'hFF);
    queue_block(16'hA5A5, 16'h5A5A, 32'hE4E4_E4E4, 64'h0000_FAC6_88FA_C688, 8'h80, 8'h80);
    queue_block(16'h5A5A, 16'hA5A5, 32'hE4E4_E4E4, 64'hDEAD_FAC6_88FA_C688, 8'hFF, 8'hFF);
    queue_block(16'h0000, 16'h0000, 32'h0000_0000, 64'hDEAD_FAC6_88FA_C688, 8'h00, 8'h00);
    queue_block(16'h1111, 16'h2222, 32'hE4E4_E4E4, 64'hFFFF_FAC6_88FA_C688, 8'hC8, 8'hC7);
    queue_random(60);
    stall_at = blocks_in + 4;
    stall_armed = 1'b1;
    drain();

    set_format(FmtUnused);
    queue_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 64'hFEDC_BA98_7654_3210, 8'hFF, 8'h00);
    queue_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, '1, 8'h00, 8'hFF);
    queue_random(35);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(FMT_COLOR);
    queue_random(55);
    drain();
    set_format(FMT_INTERP);
    queue_random(45);
    drain();
    set_format(FMT_EXPLICIT);
    queue_random(35);
    drain();

    $display("%0d blocks in, %0d pixels checked across all four format codes,", blocks_in,
             pixels_out);
    $display("with input/output idling and one %0d-cycle output stall", HoldCycles);
    if (err_cnt == 0) begin
      $display("tb_bc_texture_block_decoder: done, clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("tb_bc_texture_block_decoder: done, errors");
    end
    $finish;
  end

endmodule
